// ===== rtl/ibf_pkg.sv =====
// Package: types, codes and decode functions for the instruction bundle former.
package ibf_pkg;

  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    ACT_PASS  = 3'd0,
    ACT_SWAP1 = 3'd1,
    ACT_SWAP2 = 3'd2,
    ACT_WIDE2 = 3'd3,
    ACT_WIDE3 = 3'd4
  } action_e;

  typedef enum logic {
    CFG_THREE_WIDE = 1'b0,
    CFG_SIM_PASS   = 1'b1
  } cfg_idx_e;

  // register codes: 0..31 general, then special ones
  localparam logic [6:0] RegZzr = 7'd64;
  localparam logic [6:0] RegSr  = 7'd65;
  localparam logic [6:0] RegPc  = 7'd66;
  localparam logic [6:0] RegGbr = 7'd67;

  typedef struct packed {
    logic [1:0] res;  // 0 fail(-1), 1 plain(0), 2 ok(1)
    logic [6:0] s;
    logic [6:0] t;
    logic [6:0] n;
    logic [6:0] sr;
    logic [6:0] sw;
    logic       fl;
  } regset_t;

  localparam logic [1:0] DecFail  = 2'd0;
  localparam logic [1:0] DecPlain = 2'd1;
  localparam logic [1:0] DecOk    = 2'd2;

  // a classified window word, handed from front to back
  typedef struct packed {
    logic [15:0] a1, a2, b1, b2, c1, c2;
    logic        third;
    logic        pf_a, pf_b, pf_c;
    logic        sf_a, sf_b, sf_c;
    logic        im_a, im_b;
    logic [1:0]  sq_ab_sw, sq_bc_sw;  // both-ways check: 0 indep, 1 dep, 2 undecodable
    logic        dep_ab, dep_bc, dep_ac;
  } cls_t;

  function automatic regset_t decode_regs(input logic [15:0] w1, input logic [15:0] w2);
    regset_t    r;
    logic [6:0] rn, rs, rt, spr;
    logic [3:0] sub;
    logic [7:0] lo;
    r   = '0;
    rn  = {2'b0, w2[10], w1[7:4]};
    rs  = {2'b0, w2[9], w1[3:0]};
    rt  = {2'b0, w2[8:4]};
    spr = RegZzr;
    sub = w2[7:4];
    lo  = w1[7:0];
    r.res = DecOk;
    r.sr = RegZzr; r.sw = RegZzr;
    if (w1[15:13] != 3'b111) begin
      r.res = DecFail;
    end else if ((w1 & 16'hEB00) == 16'hE000) begin
      if (w2[15:12] >= 4'hC) begin
        r.res = DecFail;
      end else if ((w2 & 16'hF008) == 16'h1008) begin
        if ((w2 & 16'hF00F) == 16'h1009) begin
          if (sub == 4'h4 || sub == 4'hC || sub == 4'hD || sub == 4'hE) spr = RegSr;
          else if (sub == 4'h9 || sub == 4'hF) r.res = DecPlain;
        end
        if ((w2 & 16'hF00F) == 16'h100A) spr = RegSr;
        if ((w2 & 16'hF00F) == 16'h100C) begin
          if (sub == 4'h2 || sub == 4'hE || sub == 4'hF) spr = RegSr;
          else if (sub == 4'h4) r.res = DecPlain;
        end
        r.s = rn; r.t = rs; r.n = rn; r.sr = spr; r.sw = spr;
      end else if ((w2 & 16'hF00F) == 16'h3000) begin
        spr = RegSr;
        if ((lo >= 8'h18 && lo <= 8'h1B) || lo == 8'h82 || lo == 8'h83) spr = 7'd15;
        r.s = rt; r.t = rt; r.n = rt; r.sr = spr; r.sw = spr;
      end else begin
        if ((w2 & 16'hF00F) == 16'h5000 || (w2 & 16'hF00F) == 16'h900C) spr = RegSr;
        if (w2[15:12] == 4'h0) begin
          r.fl = 1'b1;
          if ((w2 & 16'hF808) == 16'h0000) r.res = DecFail;
          else if (rs == 7'd0) r.res = DecFail;
          else if (rs == 7'd1) begin
            rs = RegGbr;
            if (rt == 7'd1) rt = 7'd0;
          end
        end
        r.s = rs; r.t = rt; r.n = rn; r.sr = spr; r.sw = spr;
      end
    end else if ((w1 & 16'hEB00) == 16'hE100) begin
      if (w2[15:12] >= 4'hC) r.res = DecFail;
      r.fl = 1'b1;
      if (rs == 7'd0) rs = RegPc;
      if (rs == 7'd1) rs = RegGbr;
      r.s = rs; r.t = RegZzr; r.n = rn;
    end else if ((w1 & 16'hEB00) == 16'hE200) begin
      if (w2[15:12] == 4'hC) spr = RegSr;
      r.s = rs; r.t = RegZzr; r.n = rn; r.sr = spr; r.sw = spr;
    end else if ((w1 & 16'hEE00) == 16'hE800) begin
      rn = {2'b0, w1[4:0]};
      r.s = (w1[7:4] < 4'h4) ? RegZzr : rn;
      r.t = RegZzr; r.n = rn;
    end else if ((w1 & 16'hEE00) == 16'hEA00) begin
      r.s = 7'd0; r.t = RegZzr; r.n = 7'd0;
    end else begin
      r.res = DecPlain;
    end
    return r;
  endfunction

  function automatic logic reads_dest(input logic [15:0] w1, input logic [15:0] w2);
    logic v;
    v = 1'b0;
    if (w1[15:8] == 8'hF0) v = ((w2 & 16'hF808) == 16'h0);
    else if (w1[15:8] == 8'hF1) v = ((w2 & 16'h8800) == 16'h0);
    return v;
  endfunction

  function automatic logic hits(input logic [6:0] rg, input regset_t o);
    return (o.n == rg) || (o.s == rg) || (o.t == rg);
  endfunction

  // 0 independent, 1 dependent, 2 undecodable
  function automatic logic [1:0] seq_check(input logic [15:0] a1, input logic [15:0] a2,
                                           input logic [15:0] b1, input logic [15:0] b2,
                                           input logic both);
    regset_t    x, y;
    logic [1:0] v;
    x = decode_regs(a1, a2);
    y = decode_regs(b1, b2);
    v = 2'd0;
    if (a1[15:8] == 8'hF4) v = 2'd1;
    else if (x.res == DecFail || y.res == DecFail) v = 2'd2;
    else if (x.res == DecPlain || y.res == DecPlain) v = 2'd1;
    else if (x.fl && y.fl) v = 2'd1;
    else if (x.n != RegZzr && hits(x.n, y)) v = 2'd1;
    else if (x.sw != RegZzr && (y.sr == x.sw || hits(x.sw, y))) v = 2'd1;
    else if (both || reads_dest(b1, b2)) begin
      if (y.n != RegZzr && hits(y.n, x)) v = 2'd1;
      else if (y.sw != RegZzr && (x.sr == y.sw || hits(y.sw, x))) v = 2'd1;
    end
    return v;
  endfunction

  function automatic logic immovable(input logic [15:0] w1, input logic [15:0] w2);
    logic v;
    v = 1'b0;
    if (w1[15:13] != 3'b111) v = 1'b1;
    else if ((w1 & 16'hFE00) == 16'hFA00) v = 1'b1;
    else if ((w1 & 16'hFC00) == 16'hF400) v = 1'b1;
    else if (w1[15:8] == 8'hF9) v = 1'b1;
    else if ((w1 & 16'hEB00) == 16'hE000)
      v = (w2[15:12] >= 4'hC) ||
          ((w2[15:12] == 4'h0 || w2[15:12] == 4'h4) && w1[3:0] == 4'h0);
    else if ((w1 & 16'hEB00) == 16'hE100)
      v = (w2[15:12] >= 4'hC) || (w1[3:0] == 4'h0);
    return v;
  endfunction

  function automatic logic valid_suffix(input logic [15:0] w1, input logic [15:0] w2);
    logic v;
    v = 1'b0;
    if (!immovable(w1, w2) && w1[15:12] == 4'hF) begin
      unique case (w1[15:8])
        8'hF0: begin
          v = 1'b1;
          if (w2[15:12] >= 4'hC) v = 1'b0;
          if ((w2 & 16'hF808) == 16'hF000) v = 1'b0;
          if (w2[15:12] == 4'h2 && w2[3:2] == 2'b01 && w2[11]) v = 1'b0;
          if ((w2 & 16'hF00F) == 16'h3000) v = 1'b0;
          if ((w2 & 16'hF003) == 16'h4000) v = 1'b0;
        end
        8'hF1: v = (w2 & 16'h8800) != 16'h0;
        8'hF2, 8'hF8: v = 1'b1;
        default: v = 1'b0;
      endcase
    end
    return v;
  endfunction

  function automatic logic valid_prefix(input logic [15:0] w1, input logic [15:0] w2);
    logic       v;
    logic [3:0] hi, lo, mid;
    hi  = w2[15:12];
    lo  = w2[3:0];
    mid = w2[7:4];
    v   = 1'b0;
    if (!immovable(w1, w2) && w1[15:12] == 4'hF) begin
      unique case (w1[15:8])
        8'hF0: begin
          if (hi == 4'd1) begin
            if (lo <= 4'd1 || (lo >= 4'd5 && lo <= 4'd7)) v = 1'b1;
            else if (lo == 4'd9) v = mid <= 4'd1 || (mid >= 4'd5 && mid <= 4'd8);
            else if (lo == 4'hC) v = mid <= 4'd1 || (mid >= 4'd5 && mid <= 4'd9);
          end else if (hi == 4'd2) begin
            v = lo == 4'd0 || lo == 4'd1 || lo == 4'd8 || lo == 4'd9;
          end else if (hi == 4'd5) begin
            v = lo <= 4'd1 || (lo >= 4'd4 && lo <= 4'd7) || lo >= 4'hC;
          end
        end
        8'hF2: begin
          if (hi <= 4'd1 || (hi >= 4'd3 && hi <= 4'd9)) v = 1'b1;
          else if (hi == 4'hC) v = w1[3:0] <= 4'd2;
        end
        8'hF8: v = w1[7:4] < 4'd8;
        default: v = 1'b0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] mark_lead(input logic [15:0] w1);
    logic [15:0] v;
    v = w1;
    if (w1[15:8] == 8'hF8) v = w1 | 16'h0100;
    else if ((w1 & 16'hFC00) == 16'hF000) v = w1 | 16'h0400;
    return v;
  endfunction

endpackage

// ===== rtl/ibf_front.sv =====
// Front end: accepts a window, decodes operands and classifies pairs.
module ibf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [15:0]      a1_i, a2_i, b1_i, b2_i, c1_i, c2_i,
  input  logic             third_i,
  output logic             cls_valid_o,
  input  logic             cls_stall_i,
  output ibf_pkg::cls_t    cls_o
);
  ibf_pkg::cls_t cls_d, cls_q;
  logic          valid_q;
  logic [15:0]   c1, c2;

  assign c1 = third_i ? c1_i : 16'h0;
  assign c2 = third_i ? c2_i : 16'h0;
  assign in_stall_o = valid_q && cls_stall_i;

  always_comb begin
    cls_d          = '0;
    cls_d.a1 = a1_i; cls_d.a2 = a2_i; cls_d.b1 = b1_i; cls_d.b2 = b2_i;
    cls_d.c1 = c1; cls_d.c2 = c2; cls_d.third = third_i;
    cls_d.pf_a     = ibf_pkg::valid_prefix(a1_i, a2_i);
    cls_d.pf_b     = ibf_pkg::valid_prefix(b1_i, b2_i);
    cls_d.pf_c     = ibf_pkg::valid_prefix(c1, c2);
    cls_d.sf_a     = ibf_pkg::valid_suffix(a1_i, a2_i);
    cls_d.sf_b     = ibf_pkg::valid_suffix(b1_i, b2_i);
    cls_d.sf_c     = ibf_pkg::valid_suffix(c1, c2);
    cls_d.im_a     = ibf_pkg::immovable(a1_i, a2_i);
    cls_d.im_b     = ibf_pkg::immovable(b1_i, b2_i);
    cls_d.sq_ab_sw = ibf_pkg::seq_check(a1_i, a2_i, b1_i, b2_i, 1'b1);
    cls_d.sq_bc_sw = ibf_pkg::seq_check(b1_i, b2_i, c1, c2, 1'b1);
    cls_d.dep_ab   = ibf_pkg::seq_check(a1_i, a2_i, b1_i, b2_i, 1'b0) != 2'd0;
    cls_d.dep_bc   = ibf_pkg::seq_check(b1_i, b2_i, c1, c2, 1'b0) != 2'd0;
    cls_d.dep_ac   = ibf_pkg::seq_check(a1_i, a2_i, c1, c2, 1'b0) != 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) cls_q <= cls_d;
  end

  assign cls_valid_o = valid_q;
  assign cls_o       = cls_q;
endmodule

// ===== rtl/ibf_queue.sv =====
// Short queue between front and back.
module ibf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  ibf_pkg::cls_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output ibf_pkg::cls_t rd_data_o
);
  localparam int unsigned PtrW = $clog2(ibf_pkg::QDepth);
  ibf_pkg::cls_t  mem_q [ibf_pkg::QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_stall_o = cnt_q == (PtrW+1)'(ibf_pkg::QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PtrW+1)'(ibf_pkg::QDepth);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_count_step;
    @(posedge clk_i) disable iff (!rst_ni) (wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1;
  endproperty
  a_count_step: assert property (p_count_step) else $error("queue count slip");

  property p_empty_ptrs;
    @(posedge clk_i) disable iff (!rst_ni) (cnt_q == '0) |-> (wp_q == rp_q);
  endproperty
  a_empty_ptrs: assert property (p_empty_ptrs) else $error("queue pointers differ");
endmodule

// ===== rtl/ibf_back.sv =====
// Back end: picks the action and rewrites the window into an output register.
module ibf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          three_wide_i,
  input  logic          sim_pass_i,
  input  logic          cls_valid_i,
  output logic          cls_stall_o,
  input  ibf_pkg::cls_t cls_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    action_o,
  output logic [3:0]    adv_o,
  output logic [15:0]   w_o [6]
);
  ibf_pkg::action_e act;
  logic [3:0]       adv;
  logic [15:0]      w [6];
  logic             valid_q;
  logic [2:0]       act_q;
  logic [3:0]       adv_q;
  logic [15:0]      w_q [6];
  logic             b_stop, a_f4c, b_f4c;
  logic [15:0]      a1, a2, b1, b2, c1, c2;

  assign a1 = cls_i.a1; assign a2 = cls_i.a2; assign b1 = cls_i.b1;
  assign b2 = cls_i.b2; assign c1 = cls_i.c1; assign c2 = cls_i.c2;
  assign a_f4c  = a1[15:8] == 8'hF4 && a2[15:14] == 2'b11;
  assign b_f4c  = b1[15:8] == 8'hF4 && b2[15:14] == 2'b11;
  assign b_stop = (b1 & 16'hFC00) == 16'hF400 || b1[15:8] == 8'hF9;

  always_comb begin
    act = ibf_pkg::ACT_PASS;
    adv = 4'd4;
    w[0] = a1; w[1] = a2; w[2] = b1; w[3] = b2; w[4] = c1; w[5] = c2;
    if (a1[15:12] == 4'hE || (a1 & 16'hFE00) == 16'hFA00) begin
      adv = 4'd4;
    end else if (a_f4c) begin
      adv = b_f4c ? 4'd12 : 4'd8;
    end else if ((a1 & 16'hFC00) == 16'hF400 || a1[15:8] == 8'hF9) begin
      adv = (b_stop && (b1 & 16'hFC00) != 16'hF000) ? 4'd4 : 4'd8;
    end else if (cls_i.im_a || cls_i.im_b) begin
      adv = 4'd4;
    end else if (!cls_i.pf_a) begin
      if (cls_i.pf_b && cls_i.sf_a && cls_i.sq_ab_sw == 2'd0 && !sim_pass_i) begin
        act = ibf_pkg::ACT_SWAP1; adv = 4'd0;
        w[0] = b1; w[1] = b2; w[2] = a1; w[3] = a2;
      end
    end else if (!cls_i.pf_b && !sim_pass_i && cls_i.third && cls_i.pf_c && cls_i.sf_b &&
                 cls_i.sq_bc_sw == 2'd0 && !cls_i.dep_ac && cls_i.dep_ab) begin
      act = ibf_pkg::ACT_SWAP2; adv = 4'd0;
      w[2] = c1; w[3] = c2; w[4] = b1; w[5] = b2;
    end else if (b_stop || (b1 & 16'hFE00) == 16'hFA00 || a1[15:8] == 8'hF1) begin
      adv = 4'd4;
    end else if (cls_i.pf_b && three_wide_i && cls_i.sf_c && !cls_i.dep_ab &&
                 !cls_i.dep_bc && !cls_i.dep_ac) begin
      act = ibf_pkg::ACT_WIDE3; adv = 4'd12;
      w[0] = ibf_pkg::mark_lead(a1); w[2] = ibf_pkg::mark_lead(b1);
    end else if (a1[15:8] == 8'hF8 || a1[15:8] == 8'hF0 || a1[15:8] == 8'hF2) begin
      if (cls_i.sf_b && !cls_i.dep_ab) begin
        act = ibf_pkg::ACT_WIDE2; adv = 4'd8;
        w[0] = ibf_pkg::mark_lead(a1);
      end
    end
  end

  assign cls_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!cls_stall_o) begin
      valid_q <= cls_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cls_stall_o && cls_valid_i) begin
      act_q <= act;
      adv_q <= adv;
      w_q   <= w;
    end
  end

  assign out_valid_o = valid_q;
  assign action_o    = act_q;
  assign adv_o       = adv_q;
  assign w_o         = w_q;

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && out_stall_i) |=> valid_q && $stable(act_q) && $stable(adv_q);
  endproperty
  a_hold: assert property (p_hold) else $error("result changed while stalled");

  property p_swap_adv;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && (act_q == ibf_pkg::ACT_SWAP1 || act_q == ibf_pkg::ACT_SWAP2))
        |-> adv_q == 4'd0;
  endproperty
  a_swap_adv: assert property (p_swap_adv) else $error("swap with nonzero advance");

  property p_wide_adv;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && act_q == ibf_pkg::ACT_WIDE3) |-> adv_q == 4'd12;
  endproperty
  a_wide_adv: assert property (p_wide_adv) else $error("bundle of three bad advance");
endmodule

// ===== rtl/instruction_bundle_former.sv =====
// Top level of the instruction bundle former.
//   channel | handshake             | payload
//   in      | in_valid/in_stall     | word_{a,b,c}_{high,low}_i, third_present_i
//   out     | out_valid/out_stall   | action_o, advance_bytes_o, new_*_o
//   cfg     | cfg_valid/cfg_ready   | cfg_index_i, cfg_data_i
// One word per cycle sustained unless stalled; words pass the front register, queue
// and result register. Reset clears all valid flags but no data registers. An output
// stall backs up through the result register and two-entry queue to the input.
module instruction_bundle_former (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] word_a_high_i,
  input  logic [15:0] word_a_low_i,
  input  logic [15:0] word_b_high_i,
  input  logic [15:0] word_b_low_i,
  input  logic [15:0] word_c_high_i,
  input  logic [15:0] word_c_low_i,
  input  logic        third_present_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action_o,
  output logic [3:0]  advance_bytes_o,
  output logic [15:0] new_a_high_o,
  output logic [15:0] new_a_low_o,
  output logic [15:0] new_b_high_o,
  output logic [15:0] new_b_low_o,
  output logic [15:0] new_c_high_o,
  output logic [15:0] new_c_low_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);
  logic          three_wide_q, sim_pass_q;
  logic          f_valid, f_stall, q_valid, q_stall;
  ibf_pkg::cls_t f_cls, q_cls;
  logic [15:0]   w [6];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_wide_q <= 1'b0;
      sim_pass_q   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ibf_pkg::cfg_idx_e'(cfg_index_i))
        ibf_pkg::CFG_THREE_WIDE: three_wide_q <= cfg_data_i;
        ibf_pkg::CFG_SIM_PASS:   sim_pass_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ibf_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a1_i(word_a_high_i), .a2_i(word_a_low_i), .b1_i(word_b_high_i), .b2_i(word_b_low_i),
    .c1_i(word_c_high_i), .c2_i(word_c_low_i), .third_i(third_present_i),
    .cls_valid_o(f_valid), .cls_stall_i(f_stall), .cls_o(f_cls)
  );

  ibf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_cls),
    .rd_valid_o(q_valid), .rd_stall_i(q_stall), .rd_data_o(q_cls)
  );

  ibf_back u_back (
    .clk_i, .rst_ni, .three_wide_i(three_wide_q), .sim_pass_i(sim_pass_q),
    .cls_valid_i(q_valid), .cls_stall_o(q_stall), .cls_i(q_cls),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .action_o, .adv_o(advance_bytes_o), .w_o(w)
  );

  assign new_a_high_o = w[0];
  assign new_a_low_o  = w[1];
  assign new_b_high_o = w[2];
  assign new_b_low_o  = w[3];
  assign new_c_high_o = w[4];
  assign new_c_low_o  = w[5];
endmodule

// ===== sim/instruction_bundle_former_tb.sv =====
// Self-checking testbench for the instruction bundle former: random and directed windows.
module instruction_bundle_former_tb;

  localparam logic [6:0] CodeZero = 7'd64;
  localparam logic [6:0] CodeStat = 7'd65;
  localparam logic [6:0] CodePc   = 7'd66;
  localparam logic [6:0] CodeGb   = 7'd67;
  localparam int         HoldOff  = 300;
  localparam int         IdleLimit = 5000;

  typedef struct packed {
    logic [5:0][15:0] w;   // a_high, a_low, b_high, b_low, c_high, c_low
    logic             third;
  } window_t;

  typedef struct packed {
    ibf_pkg::action_e act;
    logic [3:0]       adv;
    logic [5:0][15:0] w;
  } step_t;

  typedef struct packed {
    logic [6:0] s, t, n, sr, sw;
    logic       fl;
  } operands_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] word_a_high_i = '0, word_a_low_i = '0, word_b_high_i = '0;
  logic [15:0] word_b_low_i = '0, word_c_high_i = '0, word_c_low_i = '0;
  logic        third_present_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action_o;
  logic [3:0]  advance_bytes_o;
  logic [15:0] new_a_high_o, new_a_low_o, new_b_high_o, new_b_low_o;
  logic [15:0] new_c_high_o, new_c_low_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index_i = 1'b0;
  logic        cfg_data_i = 1'b0;

  instruction_bundle_former dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the mode bits
  logic    wide3_on = 1'b0;
  logic    sizing_on = 1'b0;

  window_t windows_pending[$];
  step_t   steps_expected[$];
  window_t offered;
  int      send_idle_pct = 0, recv_idle_pct = 0;
  int      errors = 0, checked = 0;
  int      act_seen[5];
  bit      hold_req = 0, hold_served = 0;
  int      hold_cnt = 0;
  int      quiet_cycles = 0;

  // ---------------- predictor ----------------
  function automatic int decode_ops(input logic [15:0] w1, input logic [15:0] w2,
                                    output operands_t r);
    logic [6:0] rn, rs, rt, spx;
    logic [3:0] sub;
    logic [7:0] lo;
    r   = '0;
    spx = CodeZero;
    rn  = {2'b0, w2[10], w1[7:4]};
    rs  = {2'b0, w2[9], w1[3:0]};
    rt  = {2'b0, w2[8:4]};
    sub = w2[7:4];
    lo  = w1[7:0];
    if (w1[15:13] != 3'b111) return -1;
    if ((w1 & 16'hEB00) == 16'hE000) begin
      if (w2[15:12] >= 4'hC) return -1;
      if ((w2 & 16'hF008) == 16'h1008) begin
        if ((w2 & 16'hF00F) == 16'h1009) begin
          if (sub == 4'h4 || sub == 4'hC || sub == 4'hD || sub == 4'hE) spx = CodeStat;
          else if (sub == 4'h9 || sub == 4'hF) return 0;
        end
        if ((w2 & 16'hF00F) == 16'h100A) spx = CodeStat;
        if ((w2 & 16'hF00F) == 16'h100C) begin
          if (sub == 4'h2 || sub == 4'hE || sub == 4'hF) spx = CodeStat;
          else if (sub == 4'h4) return 0;
        end
        r = '{rn, rs, rn, spx, spx, 1'b0};
        return 1;
      end
      if ((w2 & 16'hF00F) == 16'h3000) begin
        spx = CodeStat;
        if ((lo >= 8'h18 && lo <= 8'h1B) || lo == 8'h82 || lo == 8'h83) spx = 7'd15;
        r = '{rt, rt, rt, spx, spx, 1'b0};
        return 1;
      end
      if ((w2 & 16'hF00F) == 16'h5000 || (w2 & 16'hF00F) == 16'h900C) spx = CodeStat;
      r.fl = 1'b0;
      if (w2[15:12] == 4'h0) begin
        if ((w2 & 16'hF808) == 16'h0) return -1;
        r.fl = 1'b1;
        if (rs == 7'd0) return -1;
        if (rs == 7'd1) begin
          rs = CodeGb;
          if (rt == 7'd1) rt = 7'd0;
        end
      end
      r.s = rs; r.t = rt; r.n = rn; r.sr = spx; r.sw = spx;
      return 1;
    end
    if ((w1 & 16'hEB00) == 16'hE100) begin
      if (w2[15:12] >= 4'hC) return -1;
      if (rs == 7'd0) rs = CodePc;
      if (rs == 7'd1) rs = CodeGb;
      r = '{rs, CodeZero, rn, CodeZero, CodeZero, 1'b1};
      return 1;
    end
    if ((w1 & 16'hEB00) == 16'hE200) begin
      if (w2[15:12] == 4'hC) spx = CodeStat;
      r = '{rs, CodeZero, rn, spx, spx, 1'b0};
      return 1;
    end
    if ((w1 & 16'hEE00) == 16'hE800) begin
      rn = {2'b0, w1[4:0]};
      r = '{(w1[7:4] < 4'h4) ? CodeZero : rn, CodeZero, rn, CodeZero, CodeZero, 1'b0};
      return 1;
    end
    if ((w1 & 16'hEE00) == 16'hEA00) begin
      r = '{7'd0, CodeZero, 7'd0, CodeZero, CodeZero, 1'b0};
      return 1;
    end
    return 0;
  endfunction

  function automatic bit touches(input logic [6:0] rg, input operands_t o);
    return o.n == rg || o.s == rg || o.t == rg;
  endfunction

  // -1 undecodable, 1 ordered, 0 independent
  function automatic int order_check(input logic [15:0] a1, a2, b1, b2, input bit both);
    operands_t x, y;
    int        rx, ry;
    bit        back;
    if (a1[15:8] == 8'hF4) return 1;
    rx = decode_ops(a1, a2, x);
    ry = decode_ops(b1, b2, y);
    if (rx < 0) return rx;
    if (ry < 0) return ry;
    if (rx == 0 || ry == 0) return 1;
    if (x.fl && y.fl) return 1;
    if (x.n != CodeZero && touches(x.n, y)) return 1;
    if (x.sw != CodeZero && (y.sr == x.sw || touches(x.sw, y))) return 1;
    // later word reading its own destination forces the reverse check
    back = both || (b1[15:8] == 8'hF0 && (b2 & 16'hF808) == 16'h0) ||
           (b1[15:8] == 8'hF1 && (b2 & 16'h8800) == 16'h0);
    if (back) begin
      if (y.n != CodeZero && touches(y.n, x)) return 1;
      if (y.sw != CodeZero && (x.sr == y.sw || touches(y.sw, x))) return 1;
    end
    return 0;
  endfunction

  function automatic bit pinned(input logic [15:0] w1, w2);
    if (w1[15:13] != 3'b111) return 1;
    if ((w1 & 16'hFE00) == 16'hFA00) return 1;
    if ((w1 & 16'hFC00) == 16'hF400) return 1;
    if (w1[15:8] == 8'hF9) return 1;
    if ((w1 & 16'hEB00) == 16'hE000)
      return w2[15:12] >= 4'hC ||
             ((w2[15:12] == 4'h0 || w2[15:12] == 4'h4) && w1[3:0] == 4'h0);
    if ((w1 & 16'hEB00) == 16'hE100) return w2[15:12] >= 4'hC || w1[3:0] == 4'h0;
    return 0;
  endfunction

  function automatic bit ok_as_tail(input logic [15:0] w1, w2);
    if (pinned(w1, w2) || w1[15:12] != 4'hF) return 0;
    case (w1[15:8])
      8'hF0: begin
        if (w2[15:12] >= 4'hC) return 0;
        if ((w2 & 16'hF808) == 16'hF000) return 0;
        if (w2[15:12] == 4'h2 && w2[3:2] == 2'b01 && w2[11]) return 0;
        if ((w2 & 16'hF00F) == 16'h3000) return 0;
        if ((w2 & 16'hF003) == 16'h4000) return 0;
        return 1;
      end
      8'hF1: return (w2 & 16'h8800) != 16'h0;
      8'hF2, 8'hF8: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit ok_as_head(input logic [15:0] w1, w2);
    logic [3:0] hi, lo, mid;
    hi = w2[15:12]; lo = w2[3:0]; mid = w2[7:4];
    if (pinned(w1, w2) || w1[15:12] != 4'hF) return 0;
    case (w1[15:8])
      8'hF0: begin
        if (hi == 4'd1) begin
          if (lo <= 4'd1 || (lo >= 4'd5 && lo <= 4'd7)) return 1;
          if (lo == 4'd9) return mid <= 4'd1 || (mid >= 4'd5 && mid <= 4'd8);
          if (lo == 4'hC) return mid <= 4'd1 || (mid >= 4'd5 && mid <= 4'd9);
          return 0;
        end
        if (hi == 4'd2) return lo == 4'd0 || lo == 4'd1 || lo == 4'd8 || lo == 4'd9;
        if (hi == 4'd5) return lo <= 4'd1 || (lo >= 4'd4 && lo <= 4'd7) || lo >= 4'hC;
        return 0;
      end
      8'hF2: begin
        if (hi <= 4'd1 || (hi >= 4'd3 && hi <= 4'd9)) return 1;
        if (hi == 4'hC) return w1[3:0] <= 4'd2;
        return 0;
      end
      8'hF8: return w1[7:4] < 4'd8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] set_bundle_bit(input logic [15:0] w1);
    if (w1[15:8] == 8'hF8) return w1 | 16'h0100;
    if ((w1 & 16'hFC00) == 16'hF000) return w1 | 16'h0400;
    return w1;
  endfunction

  function automatic step_t bundle_step(input window_t x);
    step_t      r;
    logic [15:0] a1, a2, b1, b2, c1, c2;
    a1 = x.w[0]; a2 = x.w[1]; b1 = x.w[2]; b2 = x.w[3];
    c1 = x.third ? x.w[4] : 16'h0;
    c2 = x.third ? x.w[5] : 16'h0;
    r.act = ibf_pkg::ACT_PASS;
    r.adv = 4'd4;
    r.w = {c2, c1, b2, b1, a2, a1};
    if (a1[15:12] == 4'hE || (a1 & 16'hFE00) == 16'hFA00) begin
      r.adv = 4'd4;
    end else if (a1[15:8] == 8'hF4 && a2[15:14] == 2'b11) begin
      r.adv = (b1[15:8] == 8'hF4 && b2[15:14] == 2'b11) ? 4'd12 : 4'd8;
    end else if ((a1 & 16'hFC00) == 16'hF400 || a1[15:8] == 8'hF9) begin
      if ((b1 & 16'hFC00) == 16'hF000) r.adv = 4'd8;
      else if ((b1 & 16'hFC00) == 16'hF400 || b1[15:8] == 8'hF9) r.adv = 4'd4;
      else r.adv = 4'd8;
    end else if (pinned(a1, a2) || pinned(b1, b2)) begin
      r.adv = 4'd4;
    end else if (!ok_as_head(a1, a2)) begin
      if (ok_as_head(b1, b2) && ok_as_tail(a1, a2) && order_check(a1, a2, b1, b2, 1) == 0
          && !sizing_on) begin
        r.act = ibf_pkg::ACT_SWAP1; r.adv = 4'd0;
        r.w[0] = b1; r.w[1] = b2; r.w[2] = a1; r.w[3] = a2;
      end
    end else if (!ok_as_head(b1, b2) && !sizing_on && x.third && ok_as_head(c1, c2) &&
                 ok_as_tail(b1, b2) && order_check(b1, b2, c1, c2, 1) == 0 &&
                 order_check(a1, a2, c1, c2, 0) == 0 &&
                 order_check(a1, a2, b1, b2, 0) != 0) begin
      r.act = ibf_pkg::ACT_SWAP2; r.adv = 4'd0;
      r.w[2] = c1; r.w[3] = c2; r.w[4] = b1; r.w[5] = b2;
    end else if ((b1 & 16'hFC00) == 16'hF400 || b1[15:8] == 8'hF9 ||
                 (b1 & 16'hFE00) == 16'hFA00 || a1[15:8] == 8'hF1) begin
      r.adv = 4'd4;
    end else if (ok_as_head(b1, b2) && wide3_on && ok_as_tail(c1, c2) &&
                 order_check(a1, a2, b1, b2, 0) == 0 &&
                 order_check(b1, b2, c1, c2, 0) == 0 &&
                 order_check(a1, a2, c1, c2, 0) == 0) begin
      r.act = ibf_pkg::ACT_WIDE3; r.adv = 4'd12;
      r.w[0] = set_bundle_bit(a1); r.w[2] = set_bundle_bit(b1);
    end else if (a1[15:8] == 8'hF8 || a1[15:8] == 8'hF0 || a1[15:8] == 8'hF2) begin
      if (ok_as_tail(b1, b2) && order_check(a1, a2, b1, b2, 0) == 0) begin
        r.act = ibf_pkg::ACT_WIDE2; r.adv = 4'd8;
        r.w[0] = set_bundle_bit(a1);
      end
    end
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic add_window(input logic [15:0] a1, a2, b1, b2, c1, c2, input bit t);
    window_t x;
    x.w = {c2, c1, b2, b1, a2, a1};
    x.third = t;
    windows_pending.push_back(x);
  endtask

  // mostly bundle-capable opcodes with few registers, so dependencies are common
  function automatic logic [31:0] random_instr();
    logic [15:0] w1, w2;
    logic [7:0]  regs;
    logic [3:0]  hi;
    regs = ($urandom_range(0, 2) != 0) ? {2'b0, 2'($urandom), 2'b0, 2'($urandom)}
                                       : 8'($urandom);
    case ($urandom_range(0, 3))
      0: hi = 4'd1;
      1: hi = 4'd2;
      2: hi = 4'd5;
      default: hi = 4'($urandom);
    endcase
    w2 = {hi, 12'($urandom)};
    if ($urandom_range(0, 1)) w2[11:8] = 4'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0, 1, 2: w1 = {8'hF0, regs};
      3:       w1 = {8'hF1, regs};
      4, 5:    w1 = {8'hF2, regs};
      6, 7:    w1 = {8'hF8, regs};
      8:       w1 = {4'hF, 4'($urandom_range(3, 15)), regs};
      9:       w1 = {4'hE, 4'($urandom), regs};
      10:      w1 = {8'hF4, regs};
      default: begin
        w1 = 16'($urandom);
        w2 = 16'($urandom);
      end
    endcase
    return {w1, w2};
  endfunction

  task automatic add_random(input int count);
    logic [31:0] a, b, c;
    repeat (count) begin
      a = random_instr();
      b = random_instr();
      c = random_instr();
      add_window(a[31:16], a[15:0], b[31:16], b[15:0], c[31:16], c[15:0],
                 $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic write_mode(input ibf_pkg::cfg_idx_e idx, input logic val);
    @(posedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ibf_pkg::CFG_THREE_WIDE) wide3_on = val;
    else sizing_on = val;
  endtask

  task automatic drain();
    while (windows_pending.size() != 0 || steps_expected.size() != 0 || in_valid)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // ---------------- input driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) steps_expected.push_back(bundle_step(offered));
      if (!in_valid || !in_stall) begin
        if (windows_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = windows_pending.pop_front();
          in_valid        <= 1'b1;
          word_a_high_i   <= offered.w[0];
          word_a_low_i    <= offered.w[1];
          word_b_high_i   <= offered.w[2];
          word_b_low_i    <= offered.w[3];
          word_c_high_i   <= offered.w[4];
          word_c_low_i    <= offered.w[5];
          third_present_i <= offered.third;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk_i) begin
    step_t exp_s;
    step_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got.act = ibf_pkg::action_e'(action_o);
      got.adv = advance_bytes_o;
      got.w = {new_c_low_o, new_c_high_o, new_b_low_o, new_b_high_o,
               new_a_low_o, new_a_high_o};
      if (steps_expected.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_s = steps_expected.pop_front();
        checked++;
        if (exp_s.act <= ibf_pkg::ACT_WIDE3) act_seen[exp_s.act]++;
        if (got.act !== exp_s.act) begin
          $error("action expected %0d got %0d", exp_s.act, action_o); errors++;
        end
        if (got.adv !== exp_s.adv) begin
          $error("advance_bytes expected %0d got %0d", exp_s.adv, got.adv); errors++;
        end
        if (got.w[0] !== exp_s.w[0]) begin
          $error("new_a_high expected %h got %h", exp_s.w[0], got.w[0]); errors++;
        end
        if (got.w[1] !== exp_s.w[1]) begin
          $error("new_a_low expected %h got %h", exp_s.w[1], got.w[1]); errors++;
        end
        if (got.w[2] !== exp_s.w[2]) begin
          $error("new_b_high expected %h got %h", exp_s.w[2], got.w[2]); errors++;
        end
        if (got.w[3] !== exp_s.w[3]) begin
          $error("new_b_low expected %h got %h", exp_s.w[3], got.w[3]); errors++;
        end
        if (got.w[4] !== exp_s.w[4]) begin
          $error("new_c_high expected %h got %h", exp_s.w[4], got.w[4]); errors++;
        end
        if (got.w[5] !== exp_s.w[5]) begin
          $error("new_c_low expected %h got %h", exp_s.w[5], got.w[5]); errors++;
        end
      end
    end
    // long hold-off lets the queue fill and back up to the input
    if (hold_req && !hold_served) begin
      hold_cnt = HoldOff;
      hold_served = 1;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_ni && (windows_pending.size() != 0 || steps_expected.size() != 0 ||
                        in_valid))
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 12; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_mode(ibf_pkg::CFG_THREE_WIDE, phase == 0 || phase == 3);
      write_mode(ibf_pkg::CFG_SIM_PASS, phase >= 2);
      if (phase == 0) begin
        add_window(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        add_window(16'hFA00, 16'h1000, 16'hF012, 16'h1000, 16'h0000, 16'h0000, 1);
        add_window(16'hF400, 16'hC000, 16'hF400, 16'hC000, 16'hF012, 16'h1000, 1);
        add_window(16'hF400, 16'hC000, 16'hF012, 16'h1000, 16'hF034, 16'h1050, 1);
        add_window(16'hF400, 16'h1000, 16'hF012, 16'h1000, 16'hF034, 16'h1050, 1);
        add_window(16'hF900, 16'h1000, 16'hF900, 16'h1000, 16'h0000, 16'h0000, 0);
        add_window(16'hF500, 16'h1000, 16'hE012, 16'h1000, 16'h0000, 16'h0000, 0);
        add_window(16'hE012, 16'h1000, 16'hF012, 16'h1000, 16'hF034, 16'h1050, 1);
        add_window(16'hF012, 16'h1000, 16'hF034, 16'h1050, 16'hF067, 16'h1080, 1);
        add_window(16'hF012, 16'h1000, 16'hF034, 16'h1050, 16'hF067, 16'h1080, 0);
        add_window(16'hF812, 16'h1000, 16'hF834, 16'h1050, 16'hF867, 16'h1080, 1);
        add_window(16'hF212, 16'h1000, 16'hF134, 16'h8850, 16'hFFFF, 16'hFFFF, 0);
        add_window(16'hF012, 16'h3001, 16'hF034, 16'h1050, 16'h1234, 16'h5678, 1);
        add_window(16'hF012, 16'h1000, 16'hF014, 16'h3001, 16'hF056, 16'h1070, 1);
        add_window(16'hF012, 16'h1000, 16'hF014, 16'h3001, 16'hF056, 16'h1070, 0);
        add_window(16'hF012, 16'h1000, 16'hF112, 16'h8800, 16'hF056, 16'h1070, 1);
        add_window(16'hF112, 16'h8800, 16'hF034, 16'h1050, 16'hF056, 16'h1070, 1);
        add_window(16'hF012, 16'h1000, 16'hF021, 16'h1000, 16'h0000, 16'h0000, 0);
        add_window(16'hF012, 16'h0108, 16'hE812, 16'h0000, 16'hEA00, 16'h0000, 1);
        add_window(16'hF011, 16'h3000, 16'hF018, 16'h3000, 16'hF034, 16'h1059, 1);
        add_window(16'hF012, 16'h100C, 16'hF034, 16'h1049, 16'hF2C1, 16'hC000, 1);
      end
      add_random(150);
      if (phase == 3) begin
        // enough items to fill the block while the receiver holds off
        while (windows_pending.size() > 140) @(posedge clk_i);
        hold_req = 1;
      end
      drain();
    end
    $display("Checked %0d results: pass %0d, swap1 %0d, swap2 %0d, two-wide %0d, three-wide %0d",
             checked, act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
    $display("Covered both mode bits in four settings, idle mixes and a long output hold-off");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== instruction_bundle_former.f =====
rtl/ibf_pkg.sv
rtl/ibf_front.sv
rtl/ibf_queue.sv
rtl/ibf_back.sv
rtl/instruction_bundle_former.sv
sim/instruction_bundle_former_tb.sv
